// File: design/msr_pkg.sv
// msr_pkg: shared types and constants for the motor speed ramp core.
// Command codes, controller states and the control/status structs.
// No dependencies.
package msr_pkg;

    localparam int SPEED_W = 9;
    localparam int RATE_W  = 10;
    localparam int MAG_W   = 8;

    // Largest speed magnitude a target may ask for.
    localparam logic signed [SPEED_W-1:0] SPEED_LIMIT = 9'sd255;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RAMP  = 2'd1,
        CMD_BRAKE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture input word, arm divider
        logic div_step;  // one quotient bit
        logic commit;    // update state, load output word
    } msr_ctl_t;

    // Datapath to controller.
    typedef struct packed {
        logic needs_div; // incoming word is a ramp or brake
        logic div_last;  // divider on its final bit
    } msr_stat_t;

endpackage

// File: design/msr_ctrl.sv
// msr_ctrl: sequencing state machine for the motor speed ramp core.
// Owns the input and output handshakes; drives the datapath via msr_ctl_t.
// Depends on msr_pkg.
module msr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  msr_pkg::msr_stat_t stat,
    output msr_pkg::msr_ctl_t  ctl
);
    import msr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        ctl.load     = 1'b0;
        ctl.div_step = 1'b0;
        ctl.commit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = stat.needs_div ? ST_DIV : ST_WRITE;
                end
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // One word in flight: after an accept the input side stays closed until the result is committed.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a word is in flight");

    // A result is only produced from the write state.
    a_commit_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (state_reg == ST_WRITE && slot_free))
        else $error("commit outside write state or into a full slot");

endmodule

// File: design/msr_datapath.sv
// msr_datapath: speed/goal/period/tick registers, bit-serial period divider
// and the output word register. Driven by msr_ctrl via msr_ctl_t.
// Depends on msr_pkg.
module msr_datapath #(
    parameter int MAX_DUTY         = 255,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   cmd,
    input  logic signed [8:0]            target_speed,
    input  logic [9:0]                   steps_per_second,
    input  msr_pkg::msr_ctl_t            ctl,
    output msr_pkg::msr_stat_t           stat,
    output logic [msr_pkg::MAG_W-1:0]    duty,
    output logic                         direction,
    output logic                         at_target
);
    import msr_pkg::*;

    localparam int PER_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int CNT_W = $clog2(PER_W);
    localparam int CAP   = (MAX_DUTY < 255) ? MAX_DUTY : 255;
    localparam logic [PER_W-1:0] TPS_BITS = PER_W'(TICKS_PER_SECOND);
    localparam logic [MAG_W-1:0] CAP_BITS = MAG_W'(CAP);

    // architectural state
    logic signed [SPEED_W-1:0] cur_reg,    cur_next;
    logic signed [SPEED_W-1:0] goal_reg,   goal_next;
    logic [PER_W-1:0]          period_reg, period_next;
    logic [PER_W-1:0]          tick_reg,   tick_next;

    // captured input word
    cmd_t                      cmd_reg;
    logic signed [SPEED_W-1:0] target_reg;
    logic [RATE_W-1:0]         rate_reg;

    // divider
    logic [RATE_W-1:0]         rem_reg;
    logic [PER_W-1:0]          quo_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [RATE_W:0]           trial;
    logic [RATE_W:0]           diff;
    logic                      fits;

    // output word
    logic [MAG_W-1:0]          duty_reg;
    logic                      direction_reg;
    logic                      at_target_reg;

    logic [PER_W-1:0]          tick_inc;
    logic                      do_step;
    logic [SPEED_W-1:0]        abs_speed;
    logic [MAG_W-1:0]          mag;
    logic [MAG_W-1:0]          capped;

    assign stat.needs_div = (cmd_t'(cmd) == CMD_RAMP) || (cmd_t'(cmd) == CMD_BRAKE);
    assign stat.div_last  = (cnt_reg == '0);

    // restoring division of the constant tick rate by the step rate
    assign trial = {rem_reg, quo_reg[PER_W-1]};
    assign diff  = trial - {1'b0, rate_reg};
    assign fits  = (trial >= {1'b0, rate_reg});

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd_t'(cmd);
            target_reg <= (target_speed < -SPEED_LIMIT) ? -SPEED_LIMIT : target_speed;
            rate_reg   <= (steps_per_second == '0) ? RATE_W'(1) : steps_per_second;
            rem_reg    <= '0;
            quo_reg    <= TPS_BITS;
            cnt_reg    <= CNT_W'(PER_W - 1);
        end
        else if (ctl.div_step)
        begin
            rem_reg <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            quo_reg <= {quo_reg[PER_W-2:0], fits};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign tick_inc = tick_reg + PER_W'(1);

    always_comb
    begin
        goal_next   = goal_reg;
        period_next = period_reg;
        tick_next   = tick_reg;
        do_step     = 1'b0;
        case (cmd_reg)
            CMD_TICK:
            begin
                if (cur_reg != goal_reg)
                begin
                    if (tick_inc >= period_reg)
                        do_step = 1'b1;
                    else
                        tick_next = tick_inc;
                end
                else
                begin
                    tick_next = '0;
                end
            end
            CMD_RAMP:
            begin
                goal_next   = target_reg;
                period_next = (quo_reg == '0) ? PER_W'(1) : quo_reg;
                do_step     = 1'b1;
            end
            CMD_BRAKE:
            begin
                goal_next   = '0;
                period_next = (quo_reg == '0) ? PER_W'(1) : quo_reg;
                do_step     = 1'b1;
            end
            default:
            begin
            end
        endcase

        cur_next = cur_reg;
        if (do_step)
        begin
            tick_next = '0;
            if (cur_reg < goal_next)
                cur_next = cur_reg + 9'sd1;
            else if (cur_reg > goal_next)
                cur_next = cur_reg - 9'sd1;
        end
    end

    assign abs_speed = cur_next[SPEED_W-1] ? SPEED_W'(-cur_next) : SPEED_W'(cur_next);
    assign mag       = abs_speed[MAG_W-1:0];
    assign capped    = (mag > CAP_BITS) ? CAP_BITS : mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            goal_reg   <= '0;
            period_reg <= TPS_BITS;
            tick_reg   <= '0;
        end
        else if (ctl.commit)
        begin
            cur_reg    <= cur_next;
            goal_reg   <= goal_next;
            period_reg <= period_next;
            tick_reg   <= tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            duty_reg      <= capped;
            direction_reg <= (cur_next > 9'sd0);
            at_target_reg <= (cur_next == goal_next);
        end
    end

    assign duty      = duty_reg;
    assign direction = direction_reg;
    assign at_target = at_target_reg;

    a_tick_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg < period_reg)
        else $error("tick count reached step period without a step");

    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        period_reg != '0)
        else $error("step period is zero");

    a_speed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg <= SPEED_LIMIT) && (cur_reg >= -SPEED_LIMIT)
        && (goal_reg <= SPEED_LIMIT) && (goal_reg >= -SPEED_LIMIT))
        else $error("speed or goal outside +-255");

endmodule

// File: design/motor_speed_ramp_core.sv
// motor_speed_ramp_core: top level of the slew-rate limited speed ramp.
// Instantiates msr_ctrl (sequencer) and msr_datapath (registers, divider).
// Depends on msr_pkg.
//
//  channel | handshake            | word
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | cmd, target_speed, steps_per_second
//  out     | out_valid / out_ready| duty, direction, at_target
//
// A tick (or unknown cmd) passes through accept, then write of the result.
// Ramp and brake also pass through the bit-serial divider between the two,
// which forms the step period, one quotient bit a cycle.
// The output register frees the input side: the next word is accepted while
// a result waits; a word whose result finds the slot still full holds there.
// Reset is asynchronous: speed, goal and tick count go to 0, period to the
// tick rate; no clearing pass.
module motor_speed_ramp_core #(
    parameter int MAX_DUTY         = 255,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                cmd,
    input  logic signed [8:0]         target_speed,
    input  logic [9:0]                steps_per_second,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [msr_pkg::MAG_W-1:0] duty,
    output logic                      direction,
    output logic                      at_target
);
    import msr_pkg::*;

    msr_ctl_t  ctl;
    msr_stat_t stat;

    msr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    msr_datapath #(
        .MAX_DUTY         (MAX_DUTY),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .target_speed     (target_speed),
        .steps_per_second (steps_per_second),
        .ctl              (ctl),
        .stat             (stat),
        .duty             (duty),
        .direction        (direction),
        .at_target        (at_target)
    );

    // Forward motion always shows a nonzero duty.
    a_dir_has_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && direction) |-> (duty != '0))
        else $error("direction set with zero duty");

endmodule

// File: sim/testbench.sv
// testbench: self-checking bench for motor_speed_ramp_core.
// Scripted words, then command-plus-tick bursts, checked against an in-bench ramp predictor.
// Depends on msr_pkg and the motor_speed_ramp_core RTL.
`timescale 1ns / 100ps

module testbench;
    import msr_pkg::*;

    localparam int TPS       = 1000;
    localparam int TOP_SPEED = 255;
    localparam int N_SCRIPT  = 20;

    typedef enum int {
        PH_FREE,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH,
        PH_PRESSURE
    } phase_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       dir;
        logic       at;
    } drive_t;

    typedef struct {
        cmd_t               op;
        logic signed [8:0]  tgt;
        logic [9:0]         rate;
        bit                 fixed;
        drive_t             val;
    } ramp_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        cmd;
    logic signed [8:0] target_speed;
    logic [9:0]        steps_per_second;
    logic              out_valid;
    logic              out_ready;
    logic [7:0]        duty;
    logic              direction;
    logic              at_target;

    // predictor state
    int pr_speed;
    int pr_goal;
    int pr_period;
    int pr_ticks;

    drive_t    drive_q[$];
    ramp_row_t ramp_script[N_SCRIPT];
    phase_t    phase;
    int        src_idle_pct;
    int        snk_stall_pct;
    int        words_sent;
    int        errors;

    motor_speed_ramp_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .target_speed     (target_speed),
        .steps_per_second (steps_per_second),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .duty             (duty),
        .direction        (direction),
        .at_target        (at_target)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic drive_t next_drive(cmd_t op, logic signed [8:0] tgt, logic [9:0] rate);
        int     goal_req;
        int     r;
        int     mag;
        bit     move;
        drive_t d;
        goal_req = int'(tgt);
        if (goal_req < -TOP_SPEED)
            goal_req = -TOP_SPEED;
        if (goal_req > TOP_SPEED)
            goal_req = TOP_SPEED;
        move = 1'b0;
        case (op)
            CMD_TICK:
            begin
                if (pr_speed != pr_goal)
                begin
                    pr_ticks++;
                    move = (pr_ticks >= pr_period);
                end
                else
                    pr_ticks = 0;
            end
            CMD_RAMP, CMD_BRAKE:
            begin
                r = (rate == 0) ? 1 : int'(rate);
                pr_period = TPS / r;
                if (pr_period == 0)
                    pr_period = 1;
                pr_goal = (op == CMD_RAMP) ? goal_req : 0;
                move = 1'b1;
            end
            default: ;
        endcase
        if (move)
        begin
            if (pr_speed < pr_goal)
                pr_speed++;
            else if (pr_speed > pr_goal)
                pr_speed--;
            pr_ticks = 0;
        end
        mag = (pr_speed < 0) ? -pr_speed : pr_speed;
        if (mag > TOP_SPEED)
            mag = TOP_SPEED;
        d.duty = mag[7:0];
        d.dir  = (pr_speed > 0);
        d.at   = (pr_speed == pr_goal);
        return d;
    endfunction

    // Offer one word; the expectation is queued at the negedge before the accepting edge.
    task automatic send_word(cmd_t op, logic signed [8:0] tgt, logic [9:0] rate,
                             bit fixed, drive_t fixed_val);
        drive_t want;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        cmd              <= op;
        target_speed     <= tgt;
        steps_per_second <= rate;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        want = next_drive(op, tgt, rate);
        drive_q.push_back(fixed ? fixed_val : want);
        words_sent++;
        @(posedge clk);
    endtask

    // Mostly a ramp or brake followed by a burst of ticks; some pure noise words.
    task automatic run_phase(phase_t ph, int budget);
        int                stop_at;
        int                burst;
        int                pick;
        cmd_t              op;
        logic signed [8:0] tgt;
        logic [9:0]        rate;
        phase = ph;
        src_idle_pct  = (ph == PH_SRC_IDLE) ? 80 : (ph == PH_BOTH) ? 9 : 0;
        snk_stall_pct = (ph == PH_SNK_STALL) ? 80 : (ph == PH_BOTH) ? 9 : 0;
        stop_at = words_sent + budget;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_word(cmd_t'($urandom_range(3)), 9'($urandom_range(511)),
                          10'($urandom_range(1023)), 1'b0, '0);
                continue;
            end
            pick = $urandom_range(9);
            if (pick < 6)
                rate = 10'($urandom_range(1023, 500));
            else if (pick < 8)
                rate = 10'($urandom_range(499, 100));
            else if (pick == 8)
                rate = 10'($urandom_range(9));
            else
                rate = 10'($urandom_range(1023));
            case ($urandom_range(7))
                0: tgt = -9'sd256;
                1: tgt = -9'sd255;
                2: tgt = 9'sd255;
                default: tgt = 9'($urandom_range(511));
            endcase
            op = ($urandom_range(4) == 0) ? CMD_BRAKE : CMD_RAMP;
            send_word(op, tgt, rate, 1'b0, '0);
            burst = ($urandom_range(7) == 0) ? $urandom_range(120, 40) : $urandom_range(25);
            if (burst > stop_at - words_sent)
                burst = stop_at - words_sent;
            repeat (burst)
                send_word(CMD_TICK, 9'($urandom_range(511)), 10'($urandom_range(1023)),
                          1'b0, '0);
        end
    endtask

    // Result side: ready pattern per phase, one long hold-off in the pressure phase.
    initial
    begin
        int     hold_left;
        bit     pressure_used;
        drive_t got;
        drive_t want;
        hold_left     = 0;
        pressure_used = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase == PH_PRESSURE && !pressure_used)
            begin
                pressure_used = 1'b1;
                hold_left     = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= snk_stall_pct);
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = '{duty, direction, at_target};
                if (drive_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("[%0t] result with none expected: duty=%0d dir=%0b at=%0b",
                                 $realtime, got.duty, got.dir, got.at);
                    errors++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                            $display("[%0t] mismatch exp/got: duty %0d/%0d %s",
                                     $realtime, want.duty, got.duty,
                                     $sformatf("dir %0b/%0b at %0b/%0b",
                                               want.dir, got.dir, want.at, got.at));
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        // op, target, rate, typed expectation, duty/dir/at
        ramp_script[0]  = '{CMD_TICK,   9'sd0,    10'd0,    1'b1, '{8'd0, 1'b0, 1'b1}};
        ramp_script[1]  = '{CMD_NONE,  -9'sd1,    10'd1023, 1'b1, '{8'd0, 1'b0, 1'b1}};
        ramp_script[2]  = '{CMD_RAMP,   9'sd255,  10'd1000, 1'b1, '{8'd1, 1'b1, 1'b0}};
        ramp_script[3]  = '{CMD_TICK,   9'sd0,    10'd0,    1'b1, '{8'd2, 1'b1, 1'b0}};
        ramp_script[4]  = '{CMD_RAMP,  -9'sd256,  10'd0,    1'b1, '{8'd1, 1'b1, 1'b0}};
        ramp_script[5]  = '{CMD_TICK,   9'sd255,  10'd1023, 1'b0, '0};
        ramp_script[6]  = '{CMD_RAMP,  -9'sd256,  10'd1023, 1'b1, '{8'd0, 1'b0, 1'b0}};
        ramp_script[7]  = '{CMD_TICK,   9'sd0,    10'd0,    1'b1, '{8'd1, 1'b0, 1'b0}};
        ramp_script[8]  = '{CMD_BRAKE,  9'sd100,  10'd1023, 1'b1, '{8'd0, 1'b0, 1'b1}};
        ramp_script[9]  = '{CMD_TICK,   9'sd0,    10'd0,    1'b1, '{8'd0, 1'b0, 1'b1}};
        ramp_script[10] = '{CMD_RAMP,   9'sd3,    10'd500,  1'b0, '0};
        ramp_script[11] = '{CMD_TICK,  -9'sd256,  10'd0,    1'b0, '0};
        ramp_script[12] = '{CMD_TICK,   9'sd0,    10'd0,    1'b0, '0};
        ramp_script[13] = '{CMD_RAMP,   9'sd3,    10'd333,  1'b0, '0};
        ramp_script[14] = '{CMD_TICK,   9'sd0,    10'd0,    1'b0, '0};
        ramp_script[15] = '{CMD_RAMP,  -9'sd255,  10'd999,  1'b0, '0};
        ramp_script[16] = '{CMD_BRAKE, -9'sd256,  10'd0,    1'b0, '0};
        ramp_script[17] = '{CMD_NONE,   9'sd255,  10'd0,    1'b0, '0};
        ramp_script[18] = '{CMD_RAMP,   9'sd255,  10'd1,    1'b0, '0};
        ramp_script[19] = '{CMD_TICK,   9'sd0,    10'd0,    1'b0, '0};

        pr_speed  = 0;
        pr_goal   = 0;
        pr_period = TPS;
        pr_ticks  = 0;
        errors        = 0;
        words_sent    = 0;
        phase         = PH_FREE;
        src_idle_pct  = 0;
        snk_stall_pct = 0;

        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        cmd              <= CMD_TICK;
        target_speed     <= '0;
        steps_per_second <= '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_SCRIPT; i++)
            send_word(ramp_script[i].op, ramp_script[i].tgt, ramp_script[i].rate,
                      ramp_script[i].fixed, ramp_script[i].val);

        run_phase(PH_FREE, 110);
        run_phase(PH_SRC_IDLE, 80);
        run_phase(PH_SNK_STALL, 80);
        run_phase(PH_BOTH, 90);
        run_phase(PH_PRESSURE, 70);

        in_valid <= 1'b0;
        phase         = PH_FREE;
        snk_stall_pct = 0;
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (30)
            @(posedge clk);

        if (errors == 0 && drive_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
design/msr_pkg.sv
design/msr_ctrl.sv
design/msr_datapath.sv
design/motor_speed_ramp_core.sv
sim/testbench.sv
